// ----- rtl/dekvt_pkg.sv -----
package dekvt_pkg;

  // Store geometry.
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [IDX_W-1:0] CENTRE   = IDX_W'(DEPTH / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD_LEFT  = 2'd0,
    OP_ADD_RIGHT = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_REMOVED   = 3'd2,
    STS_FULL      = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_RUN
  } fsm_e;

  // Per-cell control issued by the sequencer.
  typedef struct packed {
    logic cmp_en;    // capture the key compare for the incoming word
    logic in_win;    // cell lies inside the occupied window
    logic load_en;   // write a new key and value
    logic upd_en;    // overwrite the value only
    logic shift_en;  // take key and value from the right-hand neighbor
  } cell_ctrl_t;

endpackage

// ----- rtl/dekvt_if.sv -----
interface dekvt_in_if;
  logic                               valid;
  logic                               ready;
  logic [dekvt_pkg::OP_W-1:0]         operation;
  logic signed [dekvt_pkg::KEY_W-1:0] key;
  logic signed [dekvt_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface dekvt_out_if;
  logic                           valid;
  logic                           ready;
  logic [dekvt_pkg::STATUS_W-1:0] status;
  logic [dekvt_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

// ----- rtl/dekvt_cell.sv -----
module dekvt_cell (
  input  logic                        clk_i,
  input  dekvt_pkg::cell_ctrl_t       ctrl_i,
  input  logic [dekvt_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [dekvt_pkg::KEY_W-1:0] wr_key_i,
  input  logic [dekvt_pkg::VAL_W-1:0] wr_val_i,
  input  logic [dekvt_pkg::KEY_W-1:0] nbr_key_i,
  input  logic [dekvt_pkg::VAL_W-1:0] nbr_val_i,
  output logic [dekvt_pkg::KEY_W-1:0] key_o,
  output logic [dekvt_pkg::VAL_W-1:0] val_o,
  output logic                        match_o
);
  import dekvt_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic             match_q;

  // Stored pair: loaded, updated in place, or shifted in from the right.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      key_q <= wr_key_i;
      val_q <= wr_val_i;
    end else if (ctrl_i.shift_en) begin
      key_q <= nbr_key_i;
      val_q <= nbr_val_i;
    end else if (ctrl_i.upd_en) begin
      val_q <= wr_val_i;
    end
  end

  // Registered key compare, valid only for cells inside the window.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= ctrl_i.in_win && (key_q == cmp_key_i);
    end
  end

  assign key_o   = key_q;
  assign val_o   = val_q;
  assign match_o = match_q;

endmodule

// ----- rtl/double_ended_key_value_table.sv -----
// Double-ended key/value table.
// Words enter on in_i (operation, key, value) and leave on out_o (status,
// entry_count); both channels move a word when valid and ready are high.
// Each item yields exactly one result word.
// An item is handled in a compare pass and a write pass: in the cycle it is accepted every cell compares
// its stored key against the new key and registers the hit; in the next
// cycle the hit is encoded, the cells are written or shifted toward the
// left in one step, and the result is loaded into the output register.
// A new word cannot be accepted while an earlier one is still in its
// compare-then-write pass through the cell chain.
// The input is held off only while an item is in work or while an earlier
// result sits unread in the output register; a stalled receiver therefore
// blocks further input but never loses a result.
// Reset empties the table: both window ends return to the centre cell and
// the count to zero. Stored keys and values are not cleared, since cells
// outside the window are never read.
module double_ended_key_value_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  dekvt_in_if.sink     in_i,
  dekvt_out_if.source  out_o
);
  import dekvt_pkg::*;

  fsm_e state_q, state_d;
  logic accept;
  logic run;

  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  logic [IDX_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] right_q, right_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [CNT_W-1:0]    out_count_q;

  cell_ctrl_t       ctrl   [DEPTH];
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0] match;

  logic             hit;
  logic [IDX_W-1:0] pos;
  logic             do_load;
  logic [IDX_W-1:0] load_idx;
  logic             do_upd;
  logic             do_shift;
  status_e          status;

  // Sequencer: the compare is made in the idle state as a word is accepted, and the run state writes back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    run        = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_i.ready = !out_valid_q || out_o.ready;
        if (in_i.valid && in_i.ready) begin
          state_d = FSM_RUN;
        end
      end
      FSM_RUN: begin
        run     = 1'b1;
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  // Item held for the write-back cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.operation;
      key_q <= in_i.key;
      val_q <= in_i.value;
    end
  end

  // Hit position; keys in the window are unique, so matches are one-hot.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign hit = |match;

  // Decision for the write-back cycle.
  always_comb begin
    left_d   = left_q;
    right_d  = right_q;
    count_d  = count_q;
    do_load  = 1'b0;
    load_idx = CENTRE;
    do_upd   = 1'b0;
    do_shift = 1'b0;
    status   = STS_NOT_FOUND;
    case (op_e'(op_q))
      OP_ADD_LEFT, OP_ADD_RIGHT: begin
        if (count_q == '0) begin
          left_d  = CENTRE;
          right_d = CENTRE;
          count_d = CNT_W'(1);
          do_load = 1'b1;
          status  = STS_INSERTED;
        end else if (hit) begin
          do_upd = 1'b1;
          status = STS_UPDATED;
        end else if (op_e'(op_q) == OP_ADD_LEFT) begin
          if (left_q == '0) begin
            status = STS_FULL;
          end else begin
            left_d   = left_q - IDX_W'(1);
            load_idx = left_q - IDX_W'(1);
            count_d  = count_q + CNT_W'(1);
            do_load  = 1'b1;
            status   = STS_INSERTED;
          end
        end else begin
          if (right_q == LAST_IDX) begin
            status = STS_FULL;
          end else begin
            right_d  = right_q + IDX_W'(1);
            load_idx = right_q + IDX_W'(1);
            count_d  = count_q + CNT_W'(1);
            do_load  = 1'b1;
            status   = STS_INSERTED;
          end
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          do_shift = 1'b1;
          count_d  = count_q - CNT_W'(1);
          status   = STS_REMOVED;
          if (count_q == CNT_W'(1)) begin
            left_d  = CENTRE;
            right_d = CENTRE;
          end else begin
            right_d = right_q - IDX_W'(1);
          end
        end
      end
      default: begin
        status = STS_NOT_FOUND;
      end
    endcase
  end

  // Window ends and pair count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= CENTRE;
      right_q <= CENTRE;
      count_q <= '0;
    end else if (run) begin
      left_q  <= left_d;
      right_q <= right_d;
      count_q <= count_d;
    end
  end

  // Row of cells; on removal, cells from the hit to just below the right end take their right neighbor's pair.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IDX_W-1:0] Idx = IDX_W'(i);
    logic [KEY_W-1:0] nbr_key;
    logic [VAL_W-1:0] nbr_val;

    if (i == DEPTH - 1) begin : g_edge
      assign nbr_key = cell_key[i];
      assign nbr_val = cell_val[i];
    end else begin : g_inner
      assign nbr_key = cell_key[i+1];
      assign nbr_val = cell_val[i+1];
    end

    always_comb begin
      ctrl[i].cmp_en   = accept;
      ctrl[i].in_win   = (count_q != '0) && (Idx >= left_q) && (Idx <= right_q);
      ctrl[i].load_en  = run && do_load && (load_idx == Idx);
      ctrl[i].upd_en   = run && do_upd && match[i];
      ctrl[i].shift_en = run && do_shift && (Idx >= pos) && (Idx < right_q);
    end

    dekvt_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .cmp_key_i (in_i.key),
      .wr_key_i  (key_q),
      .wr_val_i  (val_q),
      .nbr_key_i (nbr_key),
      .nbr_val_i (nbr_val),
      .key_o     (cell_key[i]),
      .val_o     (cell_val[i]),
      .match_o   (match[i])
    );
  end

  // Output register.
  assign out_status_d = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;

endmodule
